@@ design/lphi_pkg.sv @@
// ----------------------------------------------------------------------------
// lphi_pkg: shared types and constants of the linear probe hash index
// operation and status codes, transaction structs, sequencer states
// ----------------------------------------------------------------------------
package lphi_pkg;

    localparam int SLOTS   = 1024;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = 10;
    localparam int KEY_W   = 64;
    localparam int PAY_W   = 64;
    localparam int ENTRY_W = KEY_W + PAY_W;
    // entry ram row: occupied flag on top of key and payload
    localparam int ROW_W   = ENTRY_W + 1;
    localparam int QDEPTH  = 2;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [2:0] {
        OP_LOOKUP   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_ERASE    = 3'd2,
        OP_ERASE_AT = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_HALF_LOAD = 3'd3,
        ST_INVALID   = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]       operation;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [9:0]       slot;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             found;
        logic [9:0]       found_slot;
        logic [PAY_W-1:0] found_payload;
        logic [9:0]       entry_count;
    } resp_t;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_LOOKUP,
        CMD_INSERT,
        CMD_ERASE,
        CMD_ERASE_AT,
        CMD_CLEAR,
        CMD_NOP,
        CMD_REJECT
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [2:0]       status;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [IDX_W-1:0] home;
        logic [IDX_W-1:0] slot;
        logic             slot_ok;
    } work_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_AT_RD,
        S_AT_CHK,
        S_MOVE_RD,
        S_MOVE_CHK,
        S_HASH_W,
        S_PLACE_RD,
        S_PLACE_CHK,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_MUL1,
        H_MIX1,
        H_MUL2,
        H_MIX2
    } hstate_t;

endpackage

@@ design/linear_probe_hash_index.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_index: 64-bit key to payload map with linear probing
// ----------------------------------------------------------------------------
// usage
// - requests enter as queue transactions: push while full is low
// - each request gives one result transaction, read with pop while empty low
// - a front end hashes the key (murmur finalizer), classifies the request and
//   hands it on through a two-entry work queue; full stays high from each
//   accept until that request is queued, so requests are taken one at a time
// - the back end walks the probe chain through a single-port entry ram that
//   holds occupied flag, key and payload, with a read and a check per slot
// - erase also reads every later slot of the cluster, rehashes its key and
//   probes from the new home slot to place it again
// - clear runs a clearing pass over all 1024 slots; rejected inserts and
//   unused codes go straight to the result state
// - reset starts the same clearing pass; the front end may accept and queue
//   requests meanwhile, the back end takes them after the pass
// - a result waits in the output register while pop is low; the back end
//   then holds in its result state and the front end keeps hashing and
//   queuing until the work queue fills, after which full stays high
// ----------------------------------------------------------------------------
module linear_probe_hash_index (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  lphi_pkg::req_t  req,
    output logic            empty,
    input  logic            pop,
    output lphi_pkg::resp_t resp
);
    import lphi_pkg::*;

    work_t work;
    logic  work_valid;
    logic  work_take;

    // front end: intake, hashing, classification, work queue
    lphi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push       (push),
        .full       (full),
        .work       (work),
        .work_valid (work_valid),
        .work_take  (work_take)
    );

    // back end: table walk and result register
    lphi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (work),
        .work_valid (work_valid),
        .work_take  (work_take),
        .resp       (resp),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

@@ design/lphi_ram.sv @@
// ----------------------------------------------------------------------------
// lphi_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module lphi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ design/lphi_hash.sv @@
// ----------------------------------------------------------------------------
// lphi_hash: murmur finalizer unit
// multi-cycle, each 64x64 low product split into three 32x32 partial products
// ----------------------------------------------------------------------------
module lphi_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lphi_pkg::KEY_W-1:0] key,
    output logic                      busy,
    output logic                      done,
    output logic [lphi_pkg::IDX_W-1:0] home
);
    import lphi_pkg::*;

    hstate_t     state_reg, state_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] pll_reg, plh_reg, phl_reg;
    logic [63:0] pll_next, plh_next, phl_next;
    logic [63:0] c_sel;
    logic [63:0] prod;
    logic        done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        pll_reg <= pll_next;
        plh_reg <= plh_next;
        phl_reg <= phl_next;
    end

    assign c_sel = (state_reg == H_MUL1) ? MIX_C1 : MIX_C2;
    // low 64 bits of x * c from registered partial products
    assign prod = pll_reg + {plh_reg[31:0], 32'd0} + {phl_reg[31:0], 32'd0};

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        pll_next   = pll_reg;
        plh_next   = plh_reg;
        phl_next   = phl_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    x_next     = key ^ (key >> 33);
                    state_next = H_MUL1;
                end
            end
            H_MUL1, H_MUL2:
            begin
                pll_next   = 64'(x_reg[31:0])  * 64'(c_sel[31:0]);
                plh_next   = 64'(x_reg[31:0])  * 64'(c_sel[63:32]);
                phl_next   = 64'(x_reg[63:32]) * 64'(c_sel[31:0]);
                state_next = (state_reg == H_MUL1) ? H_MIX1 : H_MIX2;
            end
            H_MIX1:
            begin
                x_next     = prod ^ (prod >> 33);
                state_next = H_MUL2;
            end
            H_MIX2:
            begin
                x_next     = prod ^ (prod >> 33);
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default: state_next = H_IDLE;
        endcase
    end

    assign busy = (state_reg != H_IDLE) || done_reg;
    assign done = done_reg;
    assign home = x_reg[IDX_W-1:0];

endmodule

@@ design/lphi_front.sv @@
// ----------------------------------------------------------------------------
// lphi_front: request intake and classification
// hashes the key, checks insert validity, queues work for the back end
// ----------------------------------------------------------------------------
module lphi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  lphi_pkg::req_t    req,
    input  logic              push,
    output logic              full,
    output lphi_pkg::work_t   work,
    output logic              work_valid,
    input  logic              work_take
);
    import lphi_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    req_t         req_reg;
    logic         hold_reg, hold_next;
    logic         hstart;
    logic         hbusy, hdone;
    logic [IDX_W-1:0] hhome;
    work_t        wq_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]  cnt_reg;
    logic         enq;
    work_t        nw;

    lphi_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hstart),
        .key   (req_reg.key),
        .busy  (hbusy),
        .done  (hdone),
        .home  (hhome)
    );

    // one request is hashed at a time; intake is held while it is in flight
    assign full   = hold_reg;
    assign hstart = hold_reg && !hbusy && !hdone && (cnt_reg < (PW+1)'(QDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    assign enq = hdone;

    always_comb
    begin
        hold_next = hold_reg;
        if (push && !hold_reg)
            hold_next = 1'b1;
        else if (enq)
            hold_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push && !hold_reg)
            req_reg <= req;
    end

    always_comb
    begin
        nw.key     = req_reg.key;
        nw.payload = req_reg.payload;
        nw.home    = hhome;
        nw.slot    = req_reg.slot[IDX_W-1:0];
        nw.slot_ok = (32'(req_reg.slot) < 32'(SLOTS));
        nw.status  = ST_OK;
        unique case (req_reg.operation)
            OP_LOOKUP:   nw.cmd = CMD_LOOKUP;
            OP_INSERT:
            begin
                if (req_reg.key == '0 || req_reg.payload == '0)
                begin
                    nw.cmd    = CMD_REJECT;
                    nw.status = ST_INVALID;
                end
                else
                    nw.cmd = CMD_INSERT;
            end
            OP_ERASE:    nw.cmd = CMD_ERASE;
            OP_ERASE_AT: nw.cmd = CMD_ERASE_AT;
            OP_CLEAR:    nw.cmd = CMD_CLEAR;
            default:     nw.cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            wq_reg[wp_reg] <= nw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (enq)
                wp_reg <= PW'((32'(wp_reg) + 1) % QDEPTH);
            if (work_take)
                rp_reg <= PW'((32'(rp_reg) + 1) % QDEPTH);
            cnt_reg <= cnt_reg + (PW+1)'(enq) - (PW+1)'(work_take);
        end
    end

    assign work       = wq_reg[rp_reg];
    assign work_valid = (cnt_reg != '0);

endmodule

@@ design/lphi_back.sv @@
// ----------------------------------------------------------------------------
// lphi_back: table sequencer
// probes, inserts, erases with cluster repair, clears, and holds the result
// ----------------------------------------------------------------------------
module lphi_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lphi_pkg::work_t  work,
    input  logic             work_valid,
    output logic             work_take,
    output lphi_pkg::resp_t  resp,
    output logic             empty,
    input  logic             pop
);
    import lphi_pkg::*;

    state_t           state_reg, state_next;
    work_t            w_reg, w_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] mp_reg, mp_next;
    logic [IDX_W:0]   n_reg, n_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] mk_reg, mk_next;
    logic [PAY_W-1:0] mv_reg, mv_next;
    resp_t            res_reg, res_next;
    resp_t            out_reg, out_next;
    logic             outv_reg, outv_next;
    logic             hstart;
    logic             hbusy, hdone;
    logic [IDX_W-1:0] hhome;

    // entry ram row: occupied flag, key, payload
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;
    logic             ro;
    logic [KEY_W-1:0] rk;
    logic [PAY_W-1:0] rv;

    lphi_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lphi_hash u_rehash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hstart),
        .key   (mk_reg),
        .busy  (hbusy),
        .done  (hdone),
        .home  (hhome)
    );

    assign ro = ram_rdata[ROW_W-1];
    assign rk = ram_rdata[ENTRY_W-1:PAY_W];
    assign rv = ram_rdata[PAY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            p_reg     <= '0;
            count_reg <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            count_reg <= count_next;
            outv_reg  <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        mp_reg  <= mp_next;
        n_reg   <= n_next;
        mk_reg  <= mk_next;
        mv_reg  <= mv_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        p_next     = p_reg;
        mp_next    = mp_reg;
        n_next     = n_reg;
        mk_next    = mk_reg;
        mv_next    = mv_reg;
        count_next = count_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        outv_next  = outv_reg;
        work_take  = 1'b0;
        hstart     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = p_reg;
        ram_wdata  = {1'b1, mk_reg, mv_reg};

        if (outv_reg && pop)
            outv_next = 1'b0;

        unique case (state_reg)
            S_INIT, S_CLR:
            begin
                // clearing pass: one row per cycle over the whole table
                ram_we    = 1'b1;
                ram_wdata = '0;
                p_next    = p_reg + 1'b1;
                if (p_reg == IDX_W'(SLOTS - 1))
                begin
                    count_next = '0;
                    if (state_reg == S_CLR)
                        state_next = S_RESP;
                    else
                        state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (work_valid)
                begin
                    work_take = 1'b1;
                    w_next    = work;
                    p_next    = work.home;
                    n_next    = '0;
                    res_next  = '0;
                    res_next.status = work.status;
                    unique case (work.cmd)
                        CMD_LOOKUP, CMD_ERASE: state_next = S_PROBE_RD;
                        CMD_INSERT:
                        begin
                            if (32'(count_reg) * 2 >= SLOTS)
                            begin
                                res_next.status = ST_HALF_LOAD;
                                state_next = S_RESP;
                            end
                            else
                                state_next = S_PROBE_RD;
                        end
                        CMD_ERASE_AT:
                        begin
                            p_next = work.slot;
                            if (work.slot_ok)
                                state_next = S_AT_RD;
                            else
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next = S_RESP;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            p_next     = '0;
                            state_next = S_CLR;
                        end
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_PROBE_RD:
            begin
                // full sweep ends the chain
                if (n_reg == (IDX_W+1)'(SLOTS))
                begin
                    if (w_reg.cmd != CMD_INSERT)
                        res_next.status = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else
                    state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (!ro)
                begin
                    // empty slot ends the chain; an insert takes it
                    if (w_reg.cmd == CMD_INSERT)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {1'b1, w_reg.key, w_reg.payload};
                        count_next = count_reg + 1'b1;
                    end
                    else
                        res_next.status = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else if (rk == w_reg.key)
                begin
                    unique case (w_reg.cmd)
                        CMD_LOOKUP:
                        begin
                            res_next.found         = 1'b1;
                            res_next.found_slot    = 10'(p_reg);
                            res_next.found_payload = rv;
                            state_next = S_RESP;
                        end
                        CMD_INSERT:
                        begin
                            res_next.status = ST_DUPLICATE;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = '0;
                            count_next = count_reg - 1'b1;
                            p_next     = p_reg + 1'b1;
                            n_next     = '0;
                            state_next = S_MOVE_RD;
                        end
                    endcase
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = S_PROBE_RD;
                end
            end
            S_AT_RD: state_next = S_AT_CHK;
            S_AT_CHK:
            begin
                if (ro && rk == w_reg.key && rv == w_reg.payload)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = '0;
                    count_next = count_reg - 1'b1;
                    p_next     = p_reg + 1'b1;
                    n_next     = '0;
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
            end
            S_MOVE_RD:
            begin
                // p_reg walks the rest of the cluster
                if (n_reg == (IDX_W+1)'(SLOTS))
                    state_next = S_RESP;
                else
                    state_next = S_MOVE_CHK;
            end
            S_MOVE_CHK:
            begin
                if (!ro)
                    state_next = S_RESP;
                else
                begin
                    mk_next    = rk;
                    mv_next    = rv;
                    ram_we     = 1'b1;
                    ram_wdata  = '0;
                    count_next = count_reg - 1'b1;
                    state_next = S_HASH_W;
                end
            end
            S_HASH_W:
            begin
                if (!hbusy && !hdone)
                    hstart = 1'b1;
                if (hdone)
                begin
                    mp_next    = hhome;
                    state_next = S_PLACE_RD;
                end
            end
            S_PLACE_RD:
            begin
                ram_addr   = mp_reg;
                state_next = S_PLACE_CHK;
            end
            S_PLACE_CHK:
            begin
                ram_addr = mp_reg;
                if (!ro)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    p_next     = p_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    mp_next    = mp_reg + 1'b1;
                    state_next = S_PLACE_RD;
                end
            end
            S_RESP:
            begin
                if (!outv_reg || pop)
                begin
                    out_next   = res_reg;
                    out_next.entry_count = count_reg;
                    outv_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign resp  = out_reg;
    assign empty = !outv_reg;

endmodule
